@@ hdl/nand_hamming_ecc_256_macros.svh @@
// Assertion macros shared by the ECC block modules.
`ifndef NAND_HAMMING_ECC_256_MACROS_SVH
`define NAND_HAMMING_ECC_256_MACROS_SVH

// checked only while out of reset
`define NHE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define NHE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

@@ hdl/nhe_pkg.sv @@
// Shared types and constants for the NAND Hamming ECC block.
package nhe_pkg;

  localparam int DEFAULT_PAGE_BYTES = 512;
  localparam int CHUNK_BYTES        = 256;

  localparam logic [23:0] SYND_MASK    = 24'h555554;
  localparam logic [1:0]  CODE_LOW_BITS = 2'b11;

  typedef enum logic {
    ENT_GEN,
    ENT_CHK
  } ent_kind_e;

  typedef enum logic [1:0] {
    ST_CLEAN  = 2'd0,
    ST_DATA   = 2'd1,
    ST_CODE   = 2'd2,
    ST_UNCORR = 2'd3
  } status_e;

  // one queue entry: a generated code word, or a syndrome to classify
  typedef struct packed {
    ent_kind_e   kind;
    logic        last;
    logic        off_hi;  // chunk index bit 0, bit 8 of the error offset
    logic [23:0] word;
  } ent_t;

endpackage

@@ hdl/nhe_front.sv @@
// Front end: byte intake, running parities, code forming and syndrome build.
module nhe_front #(
  parameter int PAGE_BYTES = nhe_pkg::DEFAULT_PAGE_BYTES
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  input  logic          cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    data_i,
  input  logic          full_i,
  output logic          push_o,
  output nhe_pkg::ent_t ent_o
);

  localparam int CHUNKS = (PAGE_BYTES / nhe_pkg::CHUNK_BYTES) < 1 ? 1 :
                          (PAGE_BYTES / nhe_pkg::CHUNK_BYTES);
  localparam int CH_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam logic [CH_W-1:0] LAST_CHUNK = CH_W'(CHUNKS - 1);
  localparam logic [1:0] POS_LAST = 2'd2;

  function automatic logic [23:0] form_code(input logic [7:0] lt,
                                            input logic [7:0] li,
                                            input logic [5:0] cp);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = '0;
    lo = '0;
    for (int k = 0; k < 4; k++) begin
      hi[7-2*k] = lt[7-k];
      hi[6-2*k] = li[7-k];
      lo[7-2*k] = lt[3-k];
      lo[6-2*k] = li[3-k];
    end
    return {~hi, ~lo, ~cp, nhe_pkg::CODE_LOW_BITS};
  endfunction

  logic            check_mode_q;
  logic [7:0]      idx_q;
  logic [CH_W-1:0] chunk_q;
  logic [5:0]      cp_q;
  logic [7:0]      lt_q, li_q;
  logic            stored_q;
  logic [1:0]      pos_q;
  logic [CH_W-1:0] sc_q;
  logic [15:0]     stash_q;
  logic [23:0]     comp_q [CHUNKS];

  logic            accept;
  logic            odd;
  logic [5:0]      cp_d;
  logic [7:0]      lt_d, li_d;
  logic [23:0]     code;
  logic            chunk_end, page_end;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    odd  = ^data_i;
    cp_d = cp_q ^ {^(data_i & 8'hf0), ^(data_i & 8'h0f), ^(data_i & 8'hcc),
                   ^(data_i & 8'h33), ^(data_i & 8'haa), ^(data_i & 8'h55)};
    lt_d = odd ? (lt_q ^ idx_q) : lt_q;
    li_d = odd ? (li_q ^ ~idx_q) : li_q;
    code = form_code(lt_d, li_d, cp_d);
  end

  assign chunk_end = (idx_q == 8'hff);
  assign page_end  = chunk_end && (chunk_q == LAST_CHUNK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_mode_q <= 1'b0;
      idx_q        <= '0;
      chunk_q      <= '0;
      cp_q         <= '0;
      lt_q         <= '0;
      li_q         <= '0;
      stored_q     <= 1'b0;
      pos_q        <= '0;
      sc_q         <= '0;
    end else if (cfg_valid_i) begin
      check_mode_q <= cfg_data_i;
      idx_q        <= '0;
      chunk_q      <= '0;
      cp_q         <= '0;
      lt_q         <= '0;
      li_q         <= '0;
      stored_q     <= 1'b0;
      pos_q        <= '0;
      sc_q         <= '0;
    end else if (accept) begin
      if (!stored_q) begin
        idx_q <= idx_q + 8'd1;
        if (chunk_end) begin
          cp_q    <= '0;
          lt_q    <= '0;
          li_q    <= '0;
          chunk_q <= page_end ? '0 : chunk_q + CH_W'(1);
          if (page_end && check_mode_q) begin
            stored_q <= 1'b1;
          end
        end else begin
          cp_q <= cp_d;
          lt_q <= lt_d;
          li_q <= li_d;
        end
      end else if (pos_q == POS_LAST) begin
        pos_q <= '0;
        if (sc_q == LAST_CHUNK) begin
          sc_q     <= '0;
          stored_q <= 1'b0;
        end else begin
          sc_q <= sc_q + CH_W'(1);
        end
      end else begin
        pos_q <= pos_q + 2'd1;
      end
    end
  end

  // stored code bytes are collected high byte first
  always_ff @(posedge clk_i) begin
    if (accept && stored_q && pos_q != POS_LAST) begin
      stash_q <= {stash_q[7:0], data_i};
    end
    if (!cfg_valid_i && accept && !stored_q && chunk_end && check_mode_q) begin
      comp_q[chunk_q] <= code;
    end
  end

  always_comb begin
    push_o = 1'b0;
    ent_o  = '{kind: nhe_pkg::ENT_GEN, last: page_end, off_hi: chunk_q[0], word: code};
    if (!stored_q) begin
      push_o = accept && chunk_end && !check_mode_q && !cfg_valid_i;
    end else begin
      push_o = accept && (pos_q == POS_LAST) && !cfg_valid_i;
      ent_o  = '{kind:   nhe_pkg::ENT_CHK,
                 last:   (sc_q == LAST_CHUNK),
                 off_hi: sc_q[0],
                 word:   comp_q[sc_q] ^ {stash_q, data_i}};
    end
  end

endmodule

@@ hdl/nhe_fifo.sv @@
// Entry queue between front and back, with a count of complete pages held.
`include "nand_hamming_ecc_256_macros.svh"

module nhe_fifo #(
  parameter int DEPTH_W = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          flush_i,
  input  logic          push_i,
  input  nhe_pkg::ent_t ent_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output logic          released_o,
  output nhe_pkg::ent_t head_o
);

  localparam int DEPTH = 2 ** DEPTH_W;

  nhe_pkg::ent_t       mem [DEPTH];
  logic [DEPTH_W-1:0]  wr_q, rd_q;
  logic [DEPTH_W:0]    cnt_q;
  logic [DEPTH_W:0]    lcnt_q;
  logic [DEPTH_W:0]    ucnt_q;
  logic                lpush, lpop;

  assign full_o     = (cnt_q == (DEPTH_W+1)'(DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign head_o     = mem[rd_q];
  // entries only leave once their page's final entry is queued
  assign released_o = (lcnt_q != '0);
  assign lpush      = push_i && ent_i.last;
  assign lpop       = pop_i && head_o.last;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      cnt_q  <= '0;
      lcnt_q <= '0;
      ucnt_q <= '0;
    end else begin
      if (pop_i)  rd_q <= rd_q + DEPTH_W'(1);
      if (flush_i) begin
        // drop the entries of a page that was cut short
        wr_q   <= wr_q - ucnt_q[DEPTH_W-1:0];
        cnt_q  <= cnt_q - ucnt_q - (DEPTH_W+1)'(pop_i);
        ucnt_q <= '0;
      end else begin
        if (push_i) wr_q <= wr_q + DEPTH_W'(1);
        if (push_i && !pop_i) begin
          cnt_q <= cnt_q + (DEPTH_W+1)'(1);
        end else if (!push_i && pop_i) begin
          cnt_q <= cnt_q - (DEPTH_W+1)'(1);
        end
        if (push_i) begin
          ucnt_q <= ent_i.last ? '0 : ucnt_q + (DEPTH_W+1)'(1);
        end
      end
      if (lpush && !lpop) begin
        lcnt_q <= lcnt_q + (DEPTH_W+1)'(1);
      end else if (!lpush && lpop) begin
        lcnt_q <= lcnt_q - (DEPTH_W+1)'(1);
      end
    end
  end

  `NHE_ASSERT(a_no_push_full, push_i |-> !full_o, "push into full queue")
  `NHE_ASSERT(a_cnt_range, cnt_q <= (DEPTH_W+1)'(DEPTH), "queue count overflow")
  `NHE_ASSERT(a_lcnt_le_cnt, lcnt_q <= cnt_q, "page count exceeds entry count")
  `NHE_ASSERT(a_no_push_flush, flush_i |-> !push_i, "push during flush")

endmodule

@@ hdl/nhe_back.sv @@
// Back end: expands code words into bytes, classifies syndromes, output register.
`include "nand_hamming_ecc_256_macros.svh"

module nhe_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic          released_i,
  input  nhe_pkg::ent_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    code_byte_o,
  output logic [1:0]    status_o,
  output logic [8:0]    error_offset_o,
  output logic [2:0]    error_bit_o,
  output logic          last_o
);

  localparam logic [1:0] SEL_LAST = 2'd2;

  logic        out_valid_q;
  logic [1:0]  sel_q;
  logic [7:0]  code_q;
  logic [1:0]  status_q;
  logic [8:0]  off_q;
  logic [2:0]  bit_q;
  logic        last_q;

  logic        go;
  logic [23:0] d;
  logic        single_data, single_bit;
  logic [7:0]  addr;
  logic [2:0]  bpos;
  nhe_pkg::status_e st;
  logic [7:0]  code_d;
  logic [1:0]  status_d;
  logic [8:0]  off_d;
  logic [2:0]  bit_d;
  logic        last_d;

  assign go    = valid_i && released_i && (!out_valid_q || out_ready_i);
  assign pop_o = go && (head_i.kind == nhe_pkg::ENT_CHK || sel_q == SEL_LAST);

  always_comb begin
    d           = head_i.word;
    single_data = ((d ^ (d >> 1)) & nhe_pkg::SYND_MASK) == nhe_pkg::SYND_MASK;
    single_bit  = ((d & (d - 24'd1)) == '0);
    addr        = {d[23], d[21], d[19], d[17], d[15], d[13], d[11], d[9]};
    bpos        = {d[7], d[5], d[3]};
    priority if (d == '0) begin
      st = nhe_pkg::ST_CLEAN;
    end else if (single_data) begin
      st = nhe_pkg::ST_DATA;
    end else if (single_bit) begin
      st = nhe_pkg::ST_CODE;
    end else begin
      st = nhe_pkg::ST_UNCORR;
    end

    code_d   = '0;
    status_d = '0;
    off_d    = '0;
    bit_d    = '0;
    last_d   = head_i.last;
    unique case (head_i.kind)
      nhe_pkg::ENT_GEN: begin
        last_d = head_i.last && (sel_q == SEL_LAST);
        unique case (sel_q)
          2'd0:    code_d = d[23:16];
          2'd1:    code_d = d[15:8];
          default: code_d = d[7:0];
        endcase
      end
      nhe_pkg::ENT_CHK: begin
        status_d = st;
        if (st == nhe_pkg::ST_DATA) begin
          off_d = {head_i.off_hi, addr};
          bit_d = bpos;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= '0;
    end else begin
      if (go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (go && head_i.kind == nhe_pkg::ENT_GEN) begin
        sel_q <= (sel_q == SEL_LAST) ? 2'd0 : sel_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      code_q   <= code_d;
      status_q <= status_d;
      off_q    <= off_d;
      bit_q    <= bit_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign code_byte_o    = code_q;
  assign status_o       = status_q;
  assign error_offset_o = off_q;
  assign error_bit_o    = bit_q;
  assign last_o         = last_q;

  `NHE_ASSERT(a_pop_released, pop_o |-> released_i, "entry left before its page completed")
  `NHE_ASSERT(a_sel_range, sel_q != 2'd3, "byte select out of range")
  `NHE_ASSERT(a_gen_pop_last, (pop_o && head_i.kind == nhe_pkg::ENT_GEN) |-> sel_q == SEL_LAST,
              "code word popped before its third byte")

endmodule

@@ hdl/nand_hamming_ecc_256.sv @@
// A page's results wait in the entry queue until its final entry is queued, then leave by
// the output register. Throughput: one byte in per cycle; one result out per ready cycle.
// Input stalls only when the entry queue (2*chunks rounded up to a power of two) is full.
// Generate mode gives 3 code bytes per 256-byte chunk; check mode one status per chunk.
// Reset (async, active low) selects generate mode, clears page position, parities and queue.
module nand_hamming_ecc_256 #(
  parameter int PAGE_BYTES = nhe_pkg::DEFAULT_PAGE_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,     // check_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] code_byte, [9:8] status,
                                      // [18:10] error_offset, [21:19] error_bit, zero pad
  output logic        m_axis_tlast
);

  localparam int CHUNKS = (PAGE_BYTES / nhe_pkg::CHUNK_BYTES) < 1 ? 1 :
                          (PAGE_BYTES / nhe_pkg::CHUNK_BYTES);
  localparam int DEPTH_W = $clog2(CHUNKS) + 1;

  logic          push, pop, full, q_valid, released;
  nhe_pkg::ent_t ent, head;
  logic [7:0]    code_byte;
  logic [1:0]    status;
  logic [8:0]    error_offset;
  logic [2:0]    error_bit;

  assign cfg_ready_o = 1'b1;

  nhe_front #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .data_i     (s_axis_tdata),
    .full_i     (full),
    .push_o     (push),
    .ent_o      (ent)
  );

  nhe_fifo #(
    .DEPTH_W(DEPTH_W)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .flush_i   (cfg_valid_i),
    .push_i    (push),
    .ent_i     (ent),
    .pop_i     (pop),
    .full_o    (full),
    .valid_o   (q_valid),
    .released_o(released),
    .head_o    (head)
  );

  nhe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .released_i    (released),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .code_byte_o   (code_byte),
    .status_o      (status),
    .error_offset_o(error_offset),
    .error_bit_o   (error_bit),
    .last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, error_bit, error_offset, status, code_byte};

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the NAND page Hamming ECC block (generate and check modes).
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGE_BYTES     = nhe_pkg::DEFAULT_PAGE_BYTES;
  localparam int CHUNKS         = (PAGE_BYTES / nhe_pkg::CHUNK_BYTES) < 1 ? 1 :
                                  PAGE_BYTES / nhe_pkg::CHUNK_BYTES;
  localparam int DATA_BYTES     = CHUNKS * nhe_pkg::CHUNK_BYTES;
  localparam int CODE_BYTES     = CHUNKS * 3;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PAGES   = 28;

  typedef struct packed {
    logic [7:0]       code;
    nhe_pkg::status_e status;
    logic [8:0]       offset;
    logic [2:0]       bit_idx;
    logic             last;
  } ecc_out_t;

  typedef enum int {FILL_ZERO, FILL_ONES, FILL_RANDOM, FILL_SPARSE, FILL_CONST} fill_e;
  typedef enum int {
    FLAW_NONE, FLAW_DATA, FLAW_DATA_FIRST, FLAW_DATA_LAST,
    FLAW_CODE, FLAW_CODE_LOW, FLAW_DOUBLE, FLAW_NOISE
  } flaw_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i    = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;     // [7:0] data_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // [7:0] code_byte, [9:8] status,
                                       // [18:10] error_offset, [21:19] error_bit
  logic        m_axis_tlast;

  nand_hamming_ecc_256 #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

  always #10 clk_i = ~clk_i;

  // stimulus side
  logic [7:0]  page_bytes_q[$];
  logic [7:0]  page_buf[DATA_BYTES];
  logic [23:0] stim_code[CHUNKS];
  logic        cur_mode = 1'b0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;

  // predictor state
  logic        check_mode_m;
  int          page_pos;
  logic [5:0]  col_par;
  logic [7:0]  line_true;
  logic [7:0]  line_inv;
  logic [23:0] chunk_code_m[CHUNKS];
  logic [7:0]  stored_m[CODE_BYTES];
  ecc_out_t    ecc_out_q[$];

  int          fail_count = 0;
  int          quiet_cycles = 0;

  function automatic logic [5:0] col_bits(input logic [7:0] v);
    return {^(v & 8'hf0), ^(v & 8'h0f), ^(v & 8'hcc), ^(v & 8'h33),
            ^(v & 8'haa), ^(v & 8'h55)};
  endfunction

  // line parity bits interleaved true/inverted, MSB pair first, parity fields inverted, low two bits ones
  function automatic logic [23:0] form_word(input logic [5:0] cp, input logic [7:0] lt,
                                            input logic [7:0] li);
    logic [7:0] hi;
    logic [7:0] lo;
    for (int k = 0; k < 4; k++) begin
      hi[7 - 2*k] = lt[7 - k];
      hi[6 - 2*k] = li[7 - k];
      lo[7 - 2*k] = lt[3 - k];
      lo[6 - 2*k] = li[3 - k];
    end
    return {~hi, ~lo, ~cp, nhe_pkg::CODE_LOW_BITS};
  endfunction

  function automatic ecc_out_t syndrome_verdict(input logic [23:0] calc,
                                                input logic [23:0] stored,
                                                input int chunk, input logic last);
    logic [23:0] syn;
    logic [7:0]  addr;
    logic [2:0]  bsel;
    ecc_out_t    o;
    syn       = calc ^ stored;
    o.code    = '0;
    o.status  = nhe_pkg::ST_CLEAN;
    o.offset  = '0;
    o.bit_idx = '0;
    o.last    = last;
    if (syn != '0) begin
      if (((syn ^ (syn >> 1)) & nhe_pkg::SYND_MASK) == nhe_pkg::SYND_MASK) begin
        for (int i = 0; i < 8; i++) addr[7 - i] = syn[23 - 2*i];
        for (int i = 0; i < 3; i++) bsel[2 - i] = syn[7 - 2*i];
        o.status  = nhe_pkg::ST_DATA;
        o.offset  = 9'(chunk * nhe_pkg::CHUNK_BYTES + addr);
        o.bit_idx = bsel;
      end else begin
        o.status = ($countones(syn) == 1) ? nhe_pkg::ST_CODE : nhe_pkg::ST_UNCORR;
      end
    end
    return o;
  endfunction

  task automatic restart_page();
    page_pos  = 0;
    col_par   = '0;
    line_true = '0;
    line_inv  = '0;
  endtask

  task automatic ecc_set_mode(input logic m);
    check_mode_m = m;
    restart_page();
  endtask

  task automatic ecc_absorb_byte(input logic [7:0] v);
    logic [7:0] idx;
    int         k;
    ecc_out_t   o;
    if (page_pos < DATA_BYTES) begin
      idx = 8'(page_pos);
      col_par ^= col_bits(v);
      if (^v) begin
        line_true ^= idx;
        line_inv  ^= ~idx;
      end
      if (idx == 8'hff) begin
        chunk_code_m[page_pos / nhe_pkg::CHUNK_BYTES] =
            form_word(col_par, line_true, line_inv);
        col_par   = '0;
        line_true = '0;
        line_inv  = '0;
      end
      page_pos++;
      if (page_pos == DATA_BYTES && !check_mode_m) begin
        for (int c = 0; c < CHUNKS; c++) begin
          for (int j = 0; j < 3; j++) begin
            o.code    = 8'(chunk_code_m[c] >> (16 - 8*j));
            o.status  = nhe_pkg::ST_CLEAN;
            o.offset  = '0;
            o.bit_idx = '0;
            o.last    = (c == CHUNKS - 1) && (j == 2);
            ecc_out_q.push_back(o);
          end
        end
        restart_page();
      end
    end else begin
      k = page_pos - DATA_BYTES;
      if (k < CODE_BYTES) stored_m[k] = v;
      page_pos++;
      if (page_pos >= DATA_BYTES + CODE_BYTES) begin
        for (int c = 0; c < CHUNKS; c++) begin
          ecc_out_q.push_back(syndrome_verdict(chunk_code_m[c],
              {stored_m[3*c], stored_m[3*c + 1], stored_m[3*c + 2]}, c, c == CHUNKS - 1));
        end
        restart_page();
      end
    end
  endtask

  task automatic report_mismatch(input string what, input ecc_out_t got, input ecc_out_t want);
    fail_count++;
    $display("%0t ns ECC result error (%s): got code %02h st %0d off %0d bit %0d last %b,",
             $time, what, got.code, got.status, got.offset, got.bit_idx, got.last,
             " want code %02h st %0d off %0d bit %0d last %b",
             want.code, want.status, want.offset, want.bit_idx, want.last);
  endtask

  // byte driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (page_bytes_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= page_bytes_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor: predicts on accepted requests, checks accepted results
  always @(posedge clk_i) begin
    ecc_out_t got;
    ecc_out_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) ecc_set_mode(cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) ecc_absorb_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got.code    = m_axis_tdata[7:0];
        got.status  = nhe_pkg::status_e'(m_axis_tdata[9:8]);
        got.offset  = m_axis_tdata[18:10];
        got.bit_idx = m_axis_tdata[21:19];
        got.last    = m_axis_tlast;
        if (ecc_out_q.size() == 0) begin
          report_mismatch("unexpected", got, got);
        end else begin
          want = ecc_out_q.pop_front();
          if (got.code !== want.code || got.status !== want.status ||
              got.offset !== want.offset || got.bit_idx !== want.bit_idx ||
              got.last !== want.last) begin
            report_mismatch("field", got, want);
          end
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles < WATCHDOG_LIMIT) begin
        quiet_cycles <= quiet_cycles + 1;
      end else begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // all bytes taken and all results back, then let the pipeline settle
  task automatic wait_idle();
    do @(negedge clk_i);
    while (page_bytes_q.size() != 0 || s_axis_tvalid || ecc_out_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    wait_idle();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_mode = m;
  endtask

  task automatic fill_page(input fill_e f);
    logic [7:0] k;
    k = 8'($urandom_range(255));
    foreach (page_buf[i]) begin
      case (f)
        FILL_ZERO:   page_buf[i] = 8'h00;
        FILL_ONES:   page_buf[i] = 8'hff;
        FILL_SPARSE: page_buf[i] = ($urandom_range(15) == 0) ? 8'($urandom_range(255)) : 8'h00;
        FILL_CONST:  page_buf[i] = k;
        default:     page_buf[i] = 8'($urandom_range(255));
      endcase
    end
  endtask

  function automatic logic [23:0] chunk_code(input int c);
    logic [5:0] cp;
    logic [7:0] lt;
    logic [7:0] li;
    logic [7:0] v;
    cp = '0;
    lt = '0;
    li = '0;
    for (int i = 0; i < nhe_pkg::CHUNK_BYTES; i++) begin
      v = page_buf[c*nhe_pkg::CHUNK_BYTES + i];
      cp ^= col_bits(v);
      if (^v) begin
        lt ^= 8'(i);
        li ^= ~8'(i);
      end
    end
    return form_word(cp, lt, li);
  endfunction

  // keeps the byte queue short so the idle settings track the stream
  task automatic push_data(input int count);
    do @(negedge clk_i);
    while (page_bytes_q.size() != 0);
    for (int i = 0; i < count; i++) page_bytes_q.push_back(page_buf[i]);
  endtask

  task automatic send_data(input fill_e f, input int count);
    fill_page(f);
    push_data(count);
  endtask

  task automatic damage_chunk(input int c, input flaw_e fl);
    int b1;
    int b2;
    b1 = $urandom_range(nhe_pkg::CHUNK_BYTES*8 - 1);
    case (fl)
      FLAW_DATA:       page_buf[c*nhe_pkg::CHUNK_BYTES + b1/8][b1%8] ^= 1'b1;
      FLAW_DATA_FIRST: page_buf[c*nhe_pkg::CHUNK_BYTES][0] ^= 1'b1;
      FLAW_DATA_LAST:  page_buf[c*nhe_pkg::CHUNK_BYTES + nhe_pkg::CHUNK_BYTES - 1][7] ^= 1'b1;
      FLAW_CODE:       stim_code[c][$urandom_range(23)] ^= 1'b1;
      FLAW_CODE_LOW:   stim_code[c][$urandom_range(1)] ^= 1'b1;
      FLAW_DOUBLE: begin
        do b2 = $urandom_range(nhe_pkg::CHUNK_BYTES*8 - 1);
        while (b2 == b1);
        page_buf[c*nhe_pkg::CHUNK_BYTES + b1/8][b1%8] ^= 1'b1;
        page_buf[c*nhe_pkg::CHUNK_BYTES + b2/8][b2%8] ^= 1'b1;
      end
      FLAW_NOISE:      stim_code[c] = 24'($urandom);
      default: ;
    endcase
  endtask

  // data bytes, then up to n_code stored code bytes, chunk order, high byte first
  task automatic send_check_page(input fill_e f, input flaw_e f0, input flaw_e f1,
                                 input int n_code);
    logic [7:0] codes[$];
    fill_page(f);
    for (int c = 0; c < CHUNKS; c++) begin
      stim_code[c] = chunk_code(c);
      damage_chunk(c, (c % 2 == 0) ? f0 : f1);
    end
    foreach (stim_code[c]) begin
      codes.push_back(stim_code[c][23:16]);
      codes.push_back(stim_code[c][15:8]);
      codes.push_back(stim_code[c][7:0]);
    end
    push_data(DATA_BYTES);
    for (int i = 0; i < n_code; i++) page_bytes_q.push_back(codes[i]);
  endtask

  initial begin
    int r;
    restart_page();
    check_mode_m = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed pages
    write_mode(1'b0);
    send_data(FILL_ZERO, DATA_BYTES);
    send_data(FILL_ONES, DATA_BYTES);
    send_data(FILL_RANDOM, 200);
    write_mode(1'b0);  // restarts the page mid-way
    send_data(FILL_RANDOM, DATA_BYTES);
    write_mode(1'b1);
    send_check_page(FILL_ZERO, FLAW_NONE, FLAW_NONE, CODE_BYTES);
    send_check_page(FILL_RANDOM, FLAW_DATA_FIRST, FLAW_DATA_LAST, CODE_BYTES);
    send_check_page(FILL_ONES, FLAW_CODE_LOW, FLAW_CODE, CODE_BYTES);
    send_check_page(FILL_RANDOM, FLAW_DOUBLE, FLAW_NOISE, CODE_BYTES);
    send_check_page(FILL_RANDOM, FLAW_NONE, FLAW_DATA, 2);
    write_mode(1'b1);  // abort inside the stored code bytes
    send_check_page(FILL_SPARSE, FLAW_DATA, FLAW_NONE, CODE_BYTES);

    // random pages, cycling through idle settings
    for (int p = 0; p < RANDOM_PAGES; p++) begin
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 61; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 61; end
        default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
      endcase
      r = $urandom_range(99);
      if (r < 30) begin
        if (r < 12) begin
          if (cur_mode) begin
            send_check_page(FILL_RANDOM, FLAW_NONE, FLAW_NONE, $urandom_range(CODE_BYTES - 1));
          end else begin
            send_data(FILL_RANDOM, $urandom_range(DATA_BYTES - 1, 1));
          end
        end
        write_mode(1'($urandom_range(1)));
      end else if (r < 40) begin
        wait_idle();  // let every result drain before the next page
      end
      if (cur_mode) begin
        send_check_page(fill_e'($urandom_range(FILL_CONST)), flaw_e'($urandom_range(FLAW_NOISE)),
                        flaw_e'($urandom_range(FLAW_NOISE)), CODE_BYTES);
      end else begin
        send_data(fill_e'($urandom_range(FILL_CONST)), DATA_BYTES);
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/nhe_pkg.sv
hdl/nhe_front.sv
hdl/nhe_fifo.sv
hdl/nhe_back.sv
hdl/nand_hamming_ecc_256.sv
tb/tb_top.sv
